>>> rtl/cbs_pkg.sv
// ----------------------------------------------------------------------------
// cbs_pkg
// Shared types and constants for the centroid bounding sphere block.
// ----------------------------------------------------------------------------
package cbs_pkg;

	localparam int MaxChildrenDef = 64;
	localparam int CoordW = 32;
	localparam int RadW = 31;
	localparam logic [RadW-1:0] RadMax = {RadW{1'b1}};

	typedef struct packed {
		logic signed [CoordW-1:0] center_x;
		logic signed [CoordW-1:0] center_y;
		logic signed [CoordW-1:0] center_z;
		logic [RadW-1:0] sphere_radius;
		logic sphere_present;
		logic last_child;
	} child_t;

	typedef struct packed {
		logic signed [CoordW-1:0] bound_x;
		logic signed [CoordW-1:0] bound_y;
		logic signed [CoordW-1:0] bound_z;
		logic [RadW-1:0] bound_radius;
		logic set_empty;
	} bound_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic div_start;
		logic scan_start;
		logic finish;
		logic empty;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
		logic scan_done;
		logic has_items;
	} status_t;

endpackage

>>> rtl/cbs_if.sv
// ----------------------------------------------------------------------------
// cbs_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface cbs_if #(
	parameter type payload_t = logic
);
	logic valid;
	logic ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/cbs_div.sv
// ----------------------------------------------------------------------------
// cbs_div
// Signed restoring divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module cbs_div
	import cbs_pkg::*;
#(
	parameter int NumW = 48,
	parameter int DenW = 11
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [NumW-1:0] num,
	input  logic [DenW-1:0] den,
	output logic done,
	output logic signed [CoordW-1:0] quot
);
	localparam int CntW = $clog2(NumW + 1);

	logic [NumW-1:0] q_q;
	logic [DenW:0] rem_q;
	logic [DenW-1:0] den_q;
	logic neg_q;
	logic busy_q;
	logic [CntW-1:0] cnt_q;
	logic [DenW:0] trial;
	logic [NumW-1:0] res;

	assign trial = {rem_q[DenW-1:0], q_q[NumW-1]};
	assign res = neg_q ? (~q_q + 1'b1) : q_q;
	assign quot = res[CoordW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CntW'(NumW);
				neg_q <= num[NumW-1];
				q_q <= num[NumW-1] ? (~num + 1'b1) : num;
				rem_q <= '0;
				den_q <= den;
			end else if (busy_q) begin
				if (trial >= {1'b0, den_q}) begin
					rem_q <= trial - {1'b0, den_q};
					q_q <= {q_q[NumW-2:0], 1'b1};
				end else begin
					rem_q <= trial;
					q_q <= {q_q[NumW-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
endmodule

>>> rtl/cbs_sqrt.sv
// ----------------------------------------------------------------------------
// cbs_sqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module cbs_sqrt (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [63:0] val,
	output logic done,
	output logic [31:0] root
);
	logic [63:0] v_q;
	logic [33:0] rem_q;
	logic [31:0] r_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic [33:0] t;
	logic [33:0] tr;

	assign t = {rem_q[31:0], v_q[63:62]};
	assign tr = {r_q, 2'b01};
	assign root = r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				v_q <= val;
				rem_q <= '0;
				r_q <= '0;
				cnt_q <= 6'd32;
			end else if (busy_q) begin
				v_q <= {v_q[61:0], 2'b00};
				if (t >= tr) begin
					rem_q <= t - tr;
					r_q <= {r_q[30:0], 1'b1};
				end else begin
					rem_q <= t;
					r_q <= {r_q[30:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
endmodule

>>> rtl/cbs_datapath.sv
// ----------------------------------------------------------------------------
// cbs_datapath
// Child store, running sums, mean dividers and the per-child reach scan.
// ----------------------------------------------------------------------------
module cbs_datapath
	import cbs_pkg::*;
#(
	parameter int MaxChildren = MaxChildrenDef
) (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  child_t child,
	output status_t status,
	output bound_t result
);
	localparam int AddrW = (MaxChildren > 1) ? $clog2(MaxChildren) : 1;
	localparam int CntW = $clog2(MaxChildren + 1);
	localparam int SumW = CoordW + CntW;
	localparam int NumW = (SumW > CoordW + 1) ? SumW : CoordW + 1;

	logic [CoordW-1:0] mem_x [MaxChildren];
	logic [CoordW-1:0] mem_y [MaxChildren];
	logic [CoordW-1:0] mem_z [MaxChildren];
	logic [RadW-1:0] mem_r [MaxChildren];

	logic signed [SumW-1:0] sum_x_q, sum_y_q, sum_z_q;
	logic [CntW-1:0] count_q;
	logic [CntW-1:0] idx_q;
	logic signed [CoordW-1:0] cx_q, cy_q, cz_q;
	logic signed [CoordW-1:0] rx_q, ry_q, rz_q;
	logic [RadW-1:0] rr_q;
	logic [RadW-1:0] best_q;
	logic [1:0] ph_q;
	logic [CntW-1:0] rd_idx;
	logic [31:0] ax_q, ay_q, az_q;
	logic [63:0] px_s1, py_s1, pz_s1;
	logic sat_q, sat_s1;
	logic [63:0] sq_sum;
	logic sq_start, sq_done;
	logic [31:0] root;
	logic [32:0] tot;
	logic [RadW-1:0] reach;
	logic dx_done, dy_done, dz_done;
	logic signed [CoordW-1:0] qx, qy, qz;
	logic [CntW-1:0] div_den;
	logic busy_q;
	logic scan_done_q;
	logic [32:0] dx, dy, dz;
	logic [32:0] mx, my, mz;

	function automatic logic [32:0] mag33(input logic [32:0] d);
		return d[32] ? (~d + 1'b1) : d;
	endfunction

	assign status.has_items = (count_q != '0);
	assign status.div_done = dx_done;
	assign status.scan_done = scan_done_q;

	always_ff @(posedge clk) begin
		if (cmd.load && child.sphere_present && count_q < CntW'(MaxChildren)) begin
			mem_x[count_q[AddrW-1:0]] <= child.center_x;
			mem_y[count_q[AddrW-1:0]] <= child.center_y;
			mem_z[count_q[AddrW-1:0]] <= child.center_z;
			mem_r[count_q[AddrW-1:0]] <= child.sphere_radius;
		end
		rx_q <= mem_x[rd_idx[AddrW-1:0]];
		ry_q <= mem_y[rd_idx[AddrW-1:0]];
		rz_q <= mem_z[rd_idx[AddrW-1:0]];
		rr_q <= mem_r[rd_idx[AddrW-1:0]];
	end

	assign rd_idx = idx_q;
	assign div_den = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_z_q <= '0;
			count_q <= '0;
		end else if (cmd.finish) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_z_q <= '0;
			count_q <= '0;
		end else if (cmd.load && child.sphere_present && count_q < CntW'(MaxChildren)) begin
			sum_x_q <= sum_x_q + SumW'(child.center_x);
			sum_y_q <= sum_y_q + SumW'(child.center_y);
			sum_z_q <= sum_z_q + SumW'(child.center_z);
			count_q <= count_q + 1'b1;
		end
	end

	cbs_div #(.NumW(NumW), .DenW(CntW)) u_div_x (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(NumW'(sum_x_q)), .den(div_den), .done(dx_done), .quot(qx));
	cbs_div #(.NumW(NumW), .DenW(CntW)) u_div_y (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(NumW'(sum_y_q)), .den(div_den), .done(dy_done), .quot(qy));
	cbs_div #(.NumW(NumW), .DenW(CntW)) u_div_z (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(NumW'(sum_z_q)), .den(div_den), .done(dz_done), .quot(qz));

	always_ff @(posedge clk) begin
		if (dx_done && dy_done && dz_done) begin
			cx_q <= qx;
			cy_q <= qy;
			cz_q <= qz;
		end
	end

	// scan phases: 0 read, 1 diff, 2 square, 3 sqrt
	assign dx = {cx_q[CoordW-1], cx_q} - {rx_q[CoordW-1], rx_q};
	assign dy = {cy_q[CoordW-1], cy_q} - {ry_q[CoordW-1], ry_q};
	assign dz = {cz_q[CoordW-1], cz_q} - {rz_q[CoordW-1], rz_q};
	assign mx = mag33(dx);
	assign my = mag33(dy);
	assign mz = mag33(dz);
	assign sq_sum = px_s1 + py_s1 + pz_s1;
	assign tot = {1'b0, root} + {2'b00, rr_q};
	assign reach = sat_s1 ? RadMax : (tot > {2'b00, RadMax}) ? RadMax : tot[RadW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ph_q <= '0;
			idx_q <= '0;
			sq_start <= 1'b0;
			scan_done_q <= 1'b0;
		end else begin
			sq_start <= 1'b0;
			scan_done_q <= 1'b0;
			if (cmd.scan_start) begin
				busy_q <= 1'b1;
				idx_q <= '0;
				ph_q <= 2'd0;
				best_q <= '0;
			end else if (busy_q) begin
				unique case (ph_q)
					2'd0: ph_q <= 2'd1;
					2'd1: begin
						ax_q <= mx[31:0];
						ay_q <= my[31:0];
						az_q <= mz[31:0];
						sat_q <= mx[32] | mx[31] | my[32] | my[31] | mz[32] | mz[31];
						ph_q <= 2'd2;
					end
					2'd2: begin
						px_s1 <= 64'(ax_q) * 64'(ax_q);
						py_s1 <= 64'(ay_q) * 64'(ay_q);
						pz_s1 <= 64'(az_q) * 64'(az_q);
						sat_s1 <= sat_q;
						sq_start <= 1'b1;
						ph_q <= 2'd3;
					end
					default: begin
						if (sq_done) begin
							if (reach > best_q) best_q <= reach;
							if (idx_q + 1'b1 == count_q) begin
								busy_q <= 1'b0;
								scan_done_q <= 1'b1;
							end else begin
								idx_q <= idx_q + 1'b1;
								ph_q <= 2'd0;
							end
						end
					end
				endcase
			end
		end
	end

	cbs_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .val(sq_sum),
		.done(sq_done), .root(root));

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result.bound_x <= cmd.empty ? '0 : cx_q;
			result.bound_y <= cmd.empty ? '0 : cy_q;
			result.bound_z <= cmd.empty ? '0 : cz_q;
			result.bound_radius <= cmd.empty ? '0 :
				((reach > best_q && sq_done) ? reach : best_q);
			result.set_empty <= cmd.empty;
		end
	end
endmodule

>>> rtl/cbs_ctrl.sv
// ----------------------------------------------------------------------------
// cbs_ctrl
// Sequencer: loads children, then runs divide and scan (skipped for an empty set), then emits a beat.
// ----------------------------------------------------------------------------
module cbs_ctrl
	import cbs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_last,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  status_t status,
	output cmd_t cmd
);
	typedef enum logic [2:0] {
		ST_LOAD, ST_DIV, ST_SCAN, ST_OUT
	} state_t;

	state_t state_q;
	logic acc;
	logic cmd_div_q, cmd_scan_q, fin_q;

	assign in_ready = (state_q == ST_LOAD) && !out_valid;
	assign acc = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		cmd.load = acc;
		cmd.div_start = (state_q == ST_DIV) && cmd_div_q && status.has_items;
		cmd.scan_start = (state_q == ST_SCAN) && cmd_scan_q;
		cmd.finish = fin_q;
		cmd.empty = !status.has_items;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			out_valid <= 1'b0;
			cmd_div_q <= 1'b0;
			cmd_scan_q <= 1'b0;
			fin_q <= 1'b0;
		end else begin
			cmd_div_q <= 1'b0;
			cmd_scan_q <= 1'b0;
			fin_q <= 1'b0;
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				ST_LOAD: begin
					if (acc && in_last) begin
						state_q <= ST_DIV;
						cmd_div_q <= 1'b1;
					end
				end
				ST_DIV: begin
					if (!status.has_items) begin
						fin_q <= 1'b1;
						state_q <= ST_OUT;
					end else if (status.div_done) begin
						cmd_scan_q <= 1'b1;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (status.scan_done) begin
						fin_q <= 1'b1;
						state_q <= ST_OUT;
					end
				end
				default: begin
					out_valid <= 1'b1;
					state_q <= ST_LOAD;
				end
			endcase
		end
	end
endmodule

>>> rtl/centroid_bounding_sphere.sv
// Loading: one beat per cycle in the load state with no result pending;
// store holds MaxChildren spheres. On the last beat, if any stored: mean via
// bit-serial dividers, then a per-child scan (sqrt unit one bit per cycle).
// No new beat is taken until the result beat leaves the output register.
// Reset clears sums, count and handshake state; the store needs no clearing.
module centroid_bounding_sphere
	import cbs_pkg::*;
#(
	parameter int MaxChildren = MaxChildrenDef
) (
	input  logic clk,
	input  logic arst_n,
	cbs_if.sink   in_ch,
	cbs_if.source out_ch
);
	cmd_t cmd;
	status_t status;
	bound_t result;
	child_t child;

	assign child = in_ch.data;
	assign out_ch.data = result;

	cbs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_last(child.last_child), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.status(status), .cmd(cmd));

	cbs_datapath #(.MaxChildren(MaxChildren)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .child(child),
		.status(status), .result(result));
endmodule

>>> bench/centroid_bounding_sphere_tb.sv
// ----------------------------------------------------------------------------
// centroid_bounding_sphere_tb
// Drives groups of child spheres into the block and checks each enclosing
// sphere against a predictor of the mean center and saturated reach.
// ----------------------------------------------------------------------------
module centroid_bounding_sphere_tb;
	import cbs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NumRandom = 570;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cbs_if #(.payload_t(child_t)) in_ch ();
	cbs_if #(.payload_t(bound_t)) out_ch ();

	centroid_bounding_sphere dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always #2 clk = ~clk;

	// predictor state
	logic signed [63:0] grp_x [MaxChildrenDef];
	logic signed [63:0] grp_y [MaxChildrenDef];
	logic signed [63:0] grp_z [MaxChildrenDef];
	logic [RadW-1:0] grp_r [MaxChildrenDef];
	logic signed [63:0] acc_x, acc_y, acc_z;
	int unsigned grp_count;

	bound_t bound_queue[$];
	int errors = 0;
	bit stim_done = 1'b0;

	typedef struct {
		child_t c;
		bit typed;
		bound_t b;
	} row_t;

	row_t rows[$];

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] abs64(logic signed [63:0] d);
		return d < 0 ? -d : d;
	endfunction

	function automatic logic [RadW-1:0] child_reach(logic signed [63:0] cx,
			logic signed [63:0] cy, logic signed [63:0] cz, int k);
		logic [63:0] ax, ay, az, span;
		ax = abs64(cx - grp_x[k]);
		ay = abs64(cy - grp_y[k]);
		az = abs64(cz - grp_z[k]);
		if (ax >= 64'h8000_0000 || ay >= 64'h8000_0000 || az >= 64'h8000_0000)
			return RadMax;
		span = int_sqrt(ax * ax + ay * ay + az * az) + 64'(grp_r[k]);
		return span > {33'd0, RadMax} ? RadMax : span[RadW-1:0];
	endfunction

	// returns 1 and the bound when the beat closes a group
	function automatic bit enclose_step(child_t c, output bound_t b);
		logic signed [63:0] cx, cy, cz;
		logic [RadW-1:0] best, r;
		b = '0;
		if (c.sphere_present && grp_count < MaxChildrenDef) begin
			grp_x[grp_count] = c.center_x;
			grp_y[grp_count] = c.center_y;
			grp_z[grp_count] = c.center_z;
			grp_r[grp_count] = c.sphere_radius;
			acc_x += c.center_x;
			acc_y += c.center_y;
			acc_z += c.center_z;
			grp_count++;
		end
		if (!c.last_child) return 1'b0;
		if (grp_count == 0) begin
			b.set_empty = 1'b1;
		end else begin
			cx = acc_x / $signed({32'd0, grp_count});
			cy = acc_y / $signed({32'd0, grp_count});
			cz = acc_z / $signed({32'd0, grp_count});
			best = '0;
			for (int k = 0; k < grp_count; k++) begin
				r = child_reach(cx, cy, cz, k);
				if (r > best) best = r;
			end
			b.bound_x = cx[31:0];
			b.bound_y = cy[31:0];
			b.bound_z = cz[31:0];
			b.bound_radius = best;
		end
		acc_x = 0;
		acc_y = 0;
		acc_z = 0;
		grp_count = 0;
		return 1'b1;
	endfunction

	task automatic report(string what, logic [127:0] got, logic [127:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
		errors++;
	endtask

	function automatic child_t make_child(logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic [RadW-1:0] r, bit p, bit l);
		child_t c;
		c.center_x = x;
		c.center_y = y;
		c.center_z = z;
		c.sphere_radius = r;
		c.sphere_present = p;
		c.last_child = l;
		return c;
	endfunction

	task automatic add_row(child_t c);
		row_t rw;
		rw.c = c;
		rw.typed = 1'b0;
		rw.b = '0;
		rows.insert(rows.size(), rw);
	endtask

	task automatic add_typed(child_t c, bound_t b);
		row_t rw;
		rw.c = c;
		rw.typed = 1'b1;
		rw.b = b;
		rows.insert(rows.size(), rw);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom();
			default: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
		endcase
	endfunction

	function automatic logic [RadW-1:0] rand_rad();
		case ($urandom_range(0, 4))
			0: return RadMax;
			1: return RadW'($urandom());
			default: return RadW'($urandom_range(0, 32'h0010_0000));
		endcase
	endfunction

	// holds the beat until accepted; valid stays high when the next gap is zero
	task automatic drive(child_t c);
		int gap;
		gap = $urandom_range(0, 3);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= c;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic send(child_t c);
		bound_t b;
		drive(c);
		if (enclose_step(c, b)) bound_queue.insert(bound_queue.size(), b);
	endtask

	initial begin
		bound_t b;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		acc_x = 0;
		acc_y = 0;
		acc_z = 0;
		grp_count = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		b = '0;
		b.set_empty = 1'b1;
		add_typed(make_child(0, 0, 0, 0, 0, 1), b);
		add_typed(make_child('1, '1, '1, RadMax, 0, 1), b);
		b = '0;
		b.bound_radius = RadMax;
		add_typed(make_child(0, 0, 0, RadMax, 1, 1), b);
		b = '0;
		b.bound_x = 32'h8000_0000;
		b.bound_y = 32'h7FFF_FFFF;
		b.bound_z = 32'h8000_0000;
		b.bound_radius = 31'd5;
		add_typed(make_child(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 5, 1, 1), b);
		// spread beyond 2^31 on the x axis
		add_row(make_child(32'h8000_0000, 0, 0, 0, 1, 0));
		add_row(make_child(32'h7FFF_FFFF, 0, 0, 0, 1, 0));
		add_row(make_child(32'h7FFF_FFFF, 0, 0, 0, 1, 1));
		add_row(make_child(32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 3, 1, 0));
		add_row(make_child(32'h1234_5678, 0, 0, 0, 0, 0));
		add_row(make_child(32'hFFFE_0000, 32'h0000_8000, 32'h0003_0000, 9, 1, 1));
		// store full: 70 spheres, the last 6 dropped
		for (int i = 0; i < 70; i++)
			add_row(make_child(32'(i * 256), 32'(-i), 32'(i * 7), RadW'(i), 1, i == 69));

		foreach (rows[i]) begin
			if (rows[i].typed) begin
				bound_t pb;
				child_t c;
				c = rows[i].c;
				void'(enclose_step(c, pb));
				if (pb !== rows[i].b) report("directed table", pb, rows[i].b);
				acc_x = 0; acc_y = 0; acc_z = 0; grp_count = 0;
				drive(c);
				bound_queue.insert(bound_queue.size(), rows[i].b);
			end else begin
				send(rows[i].c);
			end
		end

		for (int n = 0; n < NumRandom; ) begin
			int len;
			len = $urandom_range(0, 9) == 0 ? $urandom_range(40, 70) : $urandom_range(1, 6);
			for (int k = 0; k < len && n < NumRandom; k++, n++)
				send(make_child(rand_coord(), rand_coord(), rand_coord(), rand_rad(),
					$urandom_range(0, 4) != 0, k == len - 1 || n == NumRandom - 1));
		end
		in_ch.valid <= 1'b0;
		stim_done = 1'b1;
	end

	initial begin
		int gap;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = $urandom_range(0, 3);
			if (gap > 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (bound_queue.size() == 0) begin
				report("unexpected beat", out_ch.data, '0);
			end else begin
				bound_t w;
				w = bound_queue.pop_front();
				if (out_ch.data.bound_x !== w.bound_x)
					report("bound_x", 128'(out_ch.data.bound_x), 128'(w.bound_x));
				if (out_ch.data.bound_y !== w.bound_y)
					report("bound_y", 128'(out_ch.data.bound_y), 128'(w.bound_y));
				if (out_ch.data.bound_z !== w.bound_z)
					report("bound_z", 128'(out_ch.data.bound_z), 128'(w.bound_z));
				if (out_ch.data.bound_radius !== w.bound_radius)
					report("bound_radius", 128'(out_ch.data.bound_radius),
						128'(w.bound_radius));
				if (out_ch.data.set_empty !== w.set_empty)
					report("set_empty", 128'(out_ch.data.set_empty), 128'(w.set_empty));
			end
		end
	end

	initial begin
		wait (stim_done);
		wait (bound_queue.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0) $display("centroid_bounding_sphere test passed");
		else $display("centroid_bounding_sphere test failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("centroid_bounding_sphere test failed");
		$finish;
	end

endmodule
